// ===== rtl/core/prls_pkg.sv =====
// Package for the priority ready list scheduler.
// Op, state and status codes, controller/datapath structs, saturating counters.
// No dependencies.
package prls_pkg;

  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_DESTROY  = 3'd1,
    OP_EXIT     = 3'd2,
    OP_SETSTATE = 3'd3,
    OP_SCHEDULE = 3'd4,
    OP_GETSTATE = 3'd5
  } op_code_t;

  localparam logic [2:0] ST_UNUSED  = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd2;
  localparam logic [2:0] ST_ZOMBIE  = 3'd5;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_BAD_ARG = 3'd1;
  localparam logic [2:0] STS_BAD_SLOT = 3'd2;
  localparam logic [2:0] STS_BAD_STATE = 3'd3;
  localparam logic [2:0] STS_FULL    = 3'd4;

  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  typedef struct packed {
    logic latch;
    logic rd;
    logic exec;
    logic push;
    logic push2;
    logic out_load;
  } prls_cmd_t;

  typedef struct packed {
    logic push_req;
    logic out_busy;
  } prls_sts_t;

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    return (v < CNT_MAX) ? v + 7'd1 : CNT_MAX;
  endfunction

  function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
    return (v != '0) ? v - 7'd1 : '0;
  endfunction

endpackage

// ===== rtl/core/prls_ctrl.sv =====
// Controller state machine for the priority ready list scheduler.
// Sequences read, execute, list push and result load. Depends on prls_pkg.
module prls_ctrl
  import prls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  prls_sts_t sts,
  output logic      in_ready,
  output prls_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_PUSH, S_PUSH2, S_DONE
  } state_t;

  state_t state_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.latch = in_fire;
    unique case (state_r)
      S_READ:  cmd.rd = 1'b1;
      S_EXEC:  cmd.exec = 1'b1;
      S_PUSH:  cmd.push = 1'b1;
      S_PUSH2: cmd.push2 = 1'b1;
      S_DONE:  cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:  if (in_fire) state_r <= S_READ;
        S_READ:  state_r <= S_EXEC;
        S_EXEC:  state_r <= sts.push_req ? S_PUSH : S_DONE;
        S_PUSH:  state_r <= S_PUSH2;
        S_PUSH2: state_r <= S_DONE;
        S_DONE:  if (!sts.out_busy) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/prls_dp.sv =====
// Datapath for the priority ready list scheduler: task table memories, used bits,
// level heads, counters and the result register. Depends on prls_pkg.
module prls_dp
  import prls_pkg::*;
#(
  parameter int TASK_SLOTS      = 64,
  parameter int PRIORITY_LEVELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  prls_cmd_t   cmd,
  output prls_sts_t   sts,
  input  logic [2:0]  in_op,
  input  logic [5:0]  in_slot,
  input  logic [2:0]  in_prio,
  input  logic [2:0]  in_tgt,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [26:0] out_bits
);

  localparam int SW  = $clog2(TASK_SLOTS);
  localparam int LKW = $clog2(TASK_SLOTS + 1);
  localparam int LVW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam logic [LKW-1:0] NULL_LINK = LKW'(TASK_SLOTS);
  localparam logic [SW-1:0]  IDLE_SLOT = SW'(1);

  logic [2:0]      state_mem [TASK_SLOTS];
  logic [LVW-1:0]  level_mem [TASK_SLOTS];
  logic [LKW-1:0]  next_mem  [TASK_SLOTS];
  logic [LKW-1:0]  prev_mem  [TASK_SLOTS];

  logic [TASK_SLOTS-1:0] used_r;
  logic [LKW-1:0]  head_r [PRIORITY_LEVELS];
  logic [SW-1:0]   cur_r;
  logic [CNT_W-1:0] live_r, exit_r;
  logic [31:0]     swt_r;

  logic [2:0]      op_r, prio_r, tgt_r;
  logic [5:0]      slot_r;
  logic [SW-1:0]   a_r;
  logic            full_r;
  logic [2:0]      rd_state;
  logic [LVW-1:0]  rd_level;
  logic [LKW-1:0]  rd_prev, rd_next;
  logic [LVW-1:0]  lv_r;
  logic [LKW-1:0]  h_r;

  logic [2:0]      res_status_r, res_state_r;
  logic [SW-1:0]   res_slot_r;
  logic            res_sw_r;
  logic            out_valid_r;
  logic [26:0]     out_bits_r;

  logic [SW-1:0]   free_idx;
  logic            free_any;
  logic [SW-1:0]   sched_slot;

  function automatic logic in_tgt_bad(input logic [2:0] t);
    return (t == ST_UNUSED) || (t > ST_ZOMBIE);
  endfunction

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
    end
    sched_slot = IDLE_SLOT;
    for (int j = 0; j < PRIORITY_LEVELS; j++) begin
      if (head_r[j] != NULL_LINK) sched_slot = head_r[j][SW-1:0];
    end
  end

  // execute decode
  logic [2:0]      e_status, e_rstate, e_ns;
  logic [SW-1:0]   e_rslot, e_cur;
  logic            e_sw, e_set_used, e_clr_used, e_st_we, e_lv_we, e_unlink, e_push;
  logic            e_change;
  logic [LVW-1:0]  e_push_lv;
  logic [CNT_W-1:0] e_live, e_exit;
  logic [31:0]     e_swt;
  logic            in_rng, valid_a;
  logic [2:0]      old_st;

  always_comb begin
    in_rng   = (32'(slot_r) < TASK_SLOTS);
    valid_a  = in_rng && used_r[a_r];
    old_st   = used_r[a_r] ? rd_state : ST_UNUSED;
    e_status = STS_OK;
    e_rstate = '0;
    e_rslot  = '0;
    e_sw     = 1'b0;
    e_cur    = cur_r;
    e_swt    = swt_r;
    e_live   = live_r;
    e_exit   = exit_r;
    e_set_used = 1'b0;
    e_clr_used = 1'b0;
    e_st_we  = 1'b0;
    e_lv_we  = 1'b0;
    e_unlink = 1'b0;
    e_push   = 1'b0;
    e_change = 1'b0;
    e_ns     = ST_ZOMBIE;
    e_push_lv = rd_level;
    unique case (op_r)
      OP_CREATE: begin
        if (32'(prio_r) >= PRIORITY_LEVELS) e_status = STS_BAD_ARG;
        else if (full_r) e_status = STS_FULL;
        else begin
          e_set_used = 1'b1;
          e_st_we    = 1'b1;
          e_ns       = ST_READY;
          e_lv_we    = 1'b1;
          e_push     = 1'b1;
          e_push_lv  = LVW'(prio_r);
          e_live     = inc_sat(live_r);
          e_rslot    = a_r;
        end
      end
      OP_DESTROY: begin
        if (!valid_a) e_status = STS_BAD_SLOT;
        else if (a_r == cur_r) e_status = STS_BAD_STATE;
        else begin
          e_unlink   = (old_st == ST_READY);
          e_clr_used = 1'b1;
          if (old_st == ST_ZOMBIE) e_exit = dec_sat(exit_r);
          else e_live = dec_sat(live_r);
        end
      end
      OP_EXIT: begin
        if (!valid_a) e_status = STS_BAD_SLOT;
        else e_change = 1'b1;
      end
      OP_SETSTATE: begin
        if (!valid_a) e_status = STS_BAD_SLOT;
        else if (in_tgt_bad(tgt_r)) e_status = STS_BAD_ARG;
        else begin
          e_change = 1'b1;
          e_ns     = tgt_r;
        end
      end
      OP_SCHEDULE: begin
        e_rslot = sched_slot;
        if (sched_slot != cur_r) begin
          if (!used_r[sched_slot]) e_status = STS_BAD_SLOT;
          else begin
            e_cur = sched_slot;
            e_sw  = 1'b1;
            if (swt_r != 32'hFFFF_FFFF) e_swt = swt_r + 32'd1;
          end
        end
      end
      OP_GETSTATE: begin
        if (!in_rng) e_status = STS_BAD_SLOT;
        else e_rstate = old_st;
      end
      default: e_status = STS_BAD_ARG;
    endcase
    if (e_change) begin
      e_unlink = (old_st == ST_READY);
      e_st_we  = 1'b1;
      e_push   = (e_ns == ST_READY);
      if (old_st == ST_ZOMBIE && e_ns != ST_ZOMBIE) begin
        e_exit = dec_sat(exit_r);
        e_live = inc_sat(live_r);
      end else if (old_st != ST_ZOMBIE && e_ns == ST_ZOMBIE) begin
        e_live = dec_sat(live_r);
        e_exit = inc_sat(exit_r);
      end
    end
  end

  // memory write ports
  logic            nx_we, pv_we;
  logic [SW-1:0]   nx_a, pv_a;
  logic [LKW-1:0]  nx_d, pv_d;
  logic            ul_p_ok, ul_n_ok;

  always_comb begin
    ul_p_ok = (rd_prev != NULL_LINK);
    ul_n_ok = (rd_next != NULL_LINK);
    nx_we = 1'b0;
    nx_a  = a_r;
    nx_d  = head_r[lv_r];
    pv_we = 1'b0;
    pv_a  = a_r;
    pv_d  = NULL_LINK;
    if (cmd.exec && e_unlink) begin
      nx_we = ul_p_ok;
      nx_a  = rd_prev[SW-1:0];
      nx_d  = rd_next;
      pv_we = ul_n_ok;
      pv_a  = rd_next[SW-1:0];
      pv_d  = rd_prev;
    end else if (cmd.push) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end else if (cmd.push2) begin
      pv_we = (h_r != NULL_LINK);
      pv_a  = h_r[SW-1:0];
      pv_d  = LKW'(a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && e_st_we) state_mem[a_r] <= e_ns;
    if (cmd.exec && e_lv_we) level_mem[a_r] <= e_push_lv;
    if (nx_we) next_mem[nx_a] <= nx_d;
    if (pv_we) prev_mem[pv_a] <= pv_d;
    if (cmd.rd) begin
      rd_state <= state_mem[a_r];
      rd_level <= level_mem[a_r];
      rd_prev  <= prev_mem[a_r];
      rd_next  <= next_mem[a_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      slot_r <= in_slot;
      prio_r <= in_prio;
      tgt_r  <= in_tgt;
      full_r <= !free_any;
      a_r    <= (in_op == OP_CREATE) ? free_idx : SW'(in_slot);
    end
    if (cmd.exec) begin
      lv_r         <= e_push_lv;
      res_status_r <= e_status;
      res_slot_r   <= e_rslot;
      res_state_r  <= e_rstate;
      res_sw_r     <= e_sw;
    end
    if (cmd.push) h_r <= head_r[lv_r];
    if (cmd.out_load) begin
      out_bits_r <= {exit_r, live_r, res_sw_r, res_state_r, 6'(res_slot_r), res_status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      cur_r       <= '0;
      live_r      <= '0;
      exit_r      <= '0;
      swt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < PRIORITY_LEVELS; k++) head_r[k] <= NULL_LINK;
    end else begin
      if (cmd.exec) begin
        cur_r      <= e_cur;
        swt_r      <= e_swt;
        live_r     <= e_live;
        exit_r     <= e_exit;
        if (e_set_used) used_r[a_r] <= 1'b1;
        if (e_clr_used) used_r[a_r] <= 1'b0;
        if (e_unlink && !ul_p_ok && head_r[rd_level] == LKW'(a_r))
          head_r[rd_level] <= rd_next;
      end
      if (cmd.push) head_r[lv_r] <= LKW'(a_r);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // decided during execute, where the controller samples it
  assign sts.push_req = e_push;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_bits     = out_bits_r;

endmodule

// ===== rtl/core/priority_ready_list_scheduler.sv =====
// Priority ready list scheduler, top level. Instantiates prls_ctrl and prls_dp.
// Each transaction runs through the memory read and execute steps, then two list-push
// write steps when the task joins a ready list, then loads the result register.
// Throughput: one item at a time; next item accepted the cycle after the
// result is loaded into the output register.
// Reset: rst_n synchronous active low; clears used bits, heads and counters.
module priority_ready_list_scheduler
  import prls_pkg::*;
#(
  parameter int TASK_SLOTS      = 64,
  parameter int PRIORITY_LEVELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[2:0], task_slot[8:3], task_priority[11:9], target_state[14:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[2:0], result_slot[8:3], result_state[11:9],
                                  // switched[12], active_tasks[19:13], zombie_tasks[26:20]
);

  prls_cmd_t   cmd;
  prls_sts_t   sts;
  logic        in_fire;
  logic [26:0] out_bits;

  assign in_fire   = in_tvalid && in_tready;
  assign out_tdata = {5'd0, out_bits};

  prls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  prls_dp #(
    .TASK_SLOTS      (TASK_SLOTS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (in_tdata[2:0]),
    .in_slot   (in_tdata[8:3]),
    .in_prio   (in_tdata[11:9]),
    .in_tgt    (in_tdata[14:12]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_bits  (out_bits)
  );

endmodule

// ===== rtl/core/prls_checker.sv =====
// Port-level checker for the priority ready list scheduler, bound to the top.
// Depends on prls_pkg.
module prls_checker
  import prls_pkg::*;
#(
  parameter int TASK_SLOTS = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= STS_FULL)
    else $error("status code out of range");

  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[2:0] == STS_OK)
    else $error("switch reported with error status");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[19:13]) + 32'(out_tdata[26:20])) <= TASK_SLOTS)
    else $error("task counts exceed table size");

endmodule

bind priority_ready_list_scheduler prls_checker #(.TASK_SLOTS(TASK_SLOTS)) u_prls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/priority_ready_list_scheduler_tb.sv =====
// Testbench for priority_ready_list_scheduler: directed and random task-table
// commands, each result checked against an in-bench scheduler model.
// Depends on prls_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module priority_ready_list_scheduler_tb;
  import prls_pkg::*;

  localparam int SLOTS    = 64;
  localparam int LEVELS   = 8;
  localparam int NIL      = SLOTS;
  localparam int IDLE     = 1;
  localparam logic [2:0] ST_CREATED = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd3;
  localparam logic [2:0] ST_BLOCKED = 3'd4;

  // packed from the top bit down, so status lands in the low bits
  typedef struct packed {
    logic [6:0] zombies;
    logic [6:0] active;
    logic       switched;
    logic [2:0] rstate;
    logic [5:0] rslot;
    logic [2:0] status;
  } sched_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  logic [15:0]   cmd_queue[$];
  sched_result_t result_queue[$];
  int            err_count;
  bit            quiet_mode;
  bit            hold_send;
  bit            in_accepted;
  int            send_gap;
  int            recv_gap;

  logic [2:0] task_state[SLOTS];
  logic [2:0] task_level[SLOTS];
  int         link_next[SLOTS];
  int         link_prev[SLOTS];
  int         level_top[LEVELS];
  int         running_task;
  logic [6:0] live_tasks;
  logic [6:0] dead_tasks;

  priority_ready_list_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [6:0] cnt_up(logic [6:0] v);
    return (v < 7'd127) ? v + 7'd1 : v;
  endfunction

  function automatic logic [6:0] cnt_down(logic [6:0] v);
    return (v != 7'd0) ? v - 7'd1 : v;
  endfunction

  function automatic bit slot_live(int s);
    return task_state[s] != ST_UNUSED;
  endfunction

  task automatic ready_push(int s);
    int lv;
    lv = task_level[s];
    link_next[s] = level_top[lv];
    link_prev[s] = NIL;
    if (level_top[lv] != NIL) link_prev[level_top[lv]] = s;
    level_top[lv] = s;
  endtask

  task automatic ready_unlink(int s);
    int lv;
    int p;
    int n;
    lv = task_level[s];
    p = link_prev[s];
    n = link_next[s];
    if (p != NIL) link_next[p] = n;
    else if (level_top[lv] == s) level_top[lv] = n;
    if (n != NIL) link_prev[n] = p;
    link_next[s] = NIL;
    link_prev[s] = NIL;
  endtask

  task automatic move_task(int s, logic [2:0] ns);
    logic [2:0] old;
    old = task_state[s];
    if (old == ST_READY) ready_unlink(s);
    if (old == ST_ZOMBIE && ns != ST_ZOMBIE) begin
      dead_tasks = cnt_down(dead_tasks);
      live_tasks = cnt_up(live_tasks);
    end else if (old != ST_ZOMBIE && ns == ST_ZOMBIE) begin
      live_tasks = cnt_down(live_tasks);
      dead_tasks = cnt_up(dead_tasks);
    end
    task_state[s] = ns;
    if (ns == ST_READY) ready_push(s);
  endtask

  task automatic sched_reset();
    for (int i = 0; i < SLOTS; i++) begin
      task_state[i] = ST_UNUSED;
      task_level[i] = '0;
      link_next[i]  = NIL;
      link_prev[i]  = NIL;
    end
    for (int i = 0; i < LEVELS; i++) level_top[i] = NIL;
    running_task = 0;
    live_tasks   = '0;
    dead_tasks   = '0;
  endtask

  task automatic sched_apply(logic [15:0] d, output sched_result_t r);
    logic [2:0] op;
    int         s;
    int         pr;
    logic [2:0] tgt;
    int         free_slot;
    op  = d[2:0];
    s   = d[8:3];
    pr  = d[11:9];
    tgt = d[14:12];
    r   = '0;
    case (op)
      OP_CREATE: begin
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (task_state[i] == ST_UNUSED) free_slot = i;
        if (free_slot < 0) r.status = STS_FULL;
        else begin
          task_level[free_slot] = pr;
          task_state[free_slot] = ST_READY;
          ready_push(free_slot);
          live_tasks = cnt_up(live_tasks);
          r.rslot = free_slot;
        end
      end
      OP_DESTROY: begin
        if (!slot_live(s)) r.status = STS_BAD_SLOT;
        else if (s == running_task) r.status = STS_BAD_STATE;
        else begin
          if (task_state[s] == ST_READY) ready_unlink(s);
          if (task_state[s] == ST_ZOMBIE) dead_tasks = cnt_down(dead_tasks);
          else live_tasks = cnt_down(live_tasks);
          task_state[s] = ST_UNUSED;
          task_level[s] = '0;
        end
      end
      OP_EXIT: begin
        if (!slot_live(s)) r.status = STS_BAD_SLOT;
        else move_task(s, ST_ZOMBIE);
      end
      OP_SETSTATE: begin
        if (!slot_live(s)) r.status = STS_BAD_SLOT;
        else if (tgt == ST_UNUSED || tgt > ST_ZOMBIE) r.status = STS_BAD_ARG;
        else move_task(s, tgt);
      end
      OP_SCHEDULE: begin
        int pick;
        pick = IDLE;
        for (int i = LEVELS - 1; i >= 0; i--)
          if (pick == IDLE && level_top[i] != NIL) begin
            pick = level_top[i];
            break;
          end
        r.rslot = pick;
        if (pick != running_task) begin
          if (!slot_live(pick)) r.status = STS_BAD_SLOT;
          else begin
            running_task = pick;
            r.switched = 1'b1;
          end
        end
      end
      OP_GETSTATE: r.rstate = task_state[s];
      default: r.status = STS_BAD_ARG;
    endcase
    r.active  = live_tasks;
    r.zombies = dead_tasks;
  endtask

  function automatic logic [15:0] pack_cmd(logic [2:0] op, logic [5:0] s,
                                           logic [2:0] pr, logic [2:0] tgt);
    return {1'b0, tgt, pr, s, op};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_accepted) begin
    end else if (send_gap > 0) begin
      send_gap  <= send_gap - 1;
      in_tvalid <= 1'b0;
    end else if (cmd_queue.size() > 0 && !hold_send) begin
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        send_gap  <= $urandom_range(1, 9) - 1;
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= cmd_queue.pop_front();
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // transaction accepted: predict on the rising edge
  always @(posedge clk) begin
    sched_result_t r;
    in_accepted <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      sched_apply(in_tdata, r);
      result_queue.push_back(r);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (recv_gap > 0) begin
      recv_gap   <= recv_gap - 1;
      out_tready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      recv_gap   <= $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  // monitor
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[26:0];
      if (result_queue.size() == 0) report_mismatch("unexpected result", got, 0);
      else begin
        want = result_queue.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.rslot !== want.rslot) report_mismatch("result_slot", got.rslot, want.rslot);
        if (got.rstate !== want.rstate)
          report_mismatch("result_state", got.rstate, want.rstate);
        if (got.switched !== want.switched)
          report_mismatch("switched", got.switched, want.switched);
        if (got.active !== want.active) report_mismatch("active_tasks", got.active, want.active);
        if (got.zombies !== want.zombies)
          report_mismatch("zombie_tasks", got.zombies, want.zombies);
      end
    end
  end

  function automatic logic [15:0] random_cmd();
    int k;
    logic [2:0] op;
    k = $urandom_range(0, 99);
    if (k < 25) op = OP_CREATE;
    else if (k < 40) op = OP_DESTROY;
    else if (k < 50) op = OP_EXIT;
    else if (k < 68) op = OP_SETSTATE;
    else if (k < 85) op = OP_SCHEDULE;
    else if (k < 96) op = OP_GETSTATE;
    else op = $urandom_range(6, 7);
    // favor low slots so commands mostly hit live tasks
    return pack_cmd(op, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 15),
                    $urandom_range(0, 7), $urandom_range(0, 7));
  endfunction

  initial begin
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    err_count  = 0;
    quiet_mode = 1'b0;
    hold_send  = 1'b0;
    in_accepted = 1'b0;
    send_gap   = 0;
    recv_gap   = 0;
    sched_reset();
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle slot unused, bad codes, empty table, extremes
    cmd_queue.push_back(pack_cmd(OP_SCHEDULE, 6'd0, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(3'd6, 6'd63, 3'd7, 3'd7));
    cmd_queue.push_back(pack_cmd(3'd7, 6'd0, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_DESTROY, 6'd63, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_GETSTATE, 6'd63, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_CREATE, 6'd0, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_CREATE, 6'd63, 3'd7, 3'd7));
    cmd_queue.push_back(pack_cmd(OP_CREATE, 6'd0, 3'd7, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_SCHEDULE, 6'd0, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_DESTROY, 6'd2, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_SETSTATE, 6'd1, 3'd0, ST_UNUSED));
    cmd_queue.push_back(pack_cmd(OP_SETSTATE, 6'd1, 3'd0, 3'd6));
    cmd_queue.push_back(pack_cmd(OP_SETSTATE, 6'd1, 3'd0, 3'd7));
    cmd_queue.push_back(pack_cmd(OP_SETSTATE, 6'd1, 3'd0, ST_READY));
    cmd_queue.push_back(pack_cmd(OP_SETSTATE, 6'd0, 3'd0, ST_BLOCKED));
    cmd_queue.push_back(pack_cmd(OP_SETSTATE, 6'd0, 3'd0, ST_CREATED));
    cmd_queue.push_back(pack_cmd(OP_SETSTATE, 6'd0, 3'd0, ST_RUNNING));
    cmd_queue.push_back(pack_cmd(OP_EXIT, 6'd1, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_EXIT, 6'd1, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_SETSTATE, 6'd1, 3'd0, ST_ZOMBIE));
    cmd_queue.push_back(pack_cmd(OP_SETSTATE, 6'd1, 3'd0, ST_READY));
    cmd_queue.push_back(pack_cmd(OP_EXIT, 6'd40, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_SCHEDULE, 6'd0, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_GETSTATE, 6'd0, 3'd0, 3'd0));
    cmd_queue.push_back(pack_cmd(OP_GETSTATE, 6'd1, 3'd0, 3'd0));
    wait (cmd_queue.size() == 0 && result_queue.size() == 0);

    // fill the table to see table full, then destroy or exit every slot
    for (int i = 0; i < 70; i++)
      cmd_queue.push_back(pack_cmd(OP_CREATE, $urandom_range(0, 63), $urandom_range(0, 7),
                                   $urandom_range(0, 7)));
    for (int i = 0; i < 64; i++)
      cmd_queue.push_back(pack_cmd($urandom_range(0, 1) ? OP_DESTROY : OP_EXIT, i,
                                   $urandom_range(0, 7), $urandom_range(0, 7)));
    cmd_queue.push_back(pack_cmd(OP_SCHEDULE, 6'd0, 3'd0, 3'd0));

    // sender holds off until every result has come
    hold_send = 1'b1;
    wait (result_queue.size() == 0 && !in_tvalid);
    hold_send = 1'b0;

    for (int i = 0; i < 250; i++) cmd_queue.push_back(random_cmd());
    wait (cmd_queue.size() == 0);
    hold_send = 1'b1;
    wait (result_queue.size() == 0 && !in_tvalid);
    hold_send = 1'b0;
    for (int i = 0; i < 200; i++) cmd_queue.push_back(random_cmd());
    wait (cmd_queue.size() < 20);
    quiet_mode = 1'b1;
    for (int i = 0; i < 60; i++) cmd_queue.push_back(random_cmd());

    wait (cmd_queue.size() == 0 && !in_tvalid && result_queue.size() == 0);
    repeat (20) @(posedge clk);
    if (err_count == 0 && result_queue.size() == 0)
      $display("priority_ready_list_scheduler_tb passed");
    else
      $display("priority_ready_list_scheduler_tb failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("priority_ready_list_scheduler_tb failed");
    $finish;
  end

endmodule
